// ===== rtl/core/rgb2hsl_pkg.sv =====
// rgb2hsl_pkg: widths, constants and types for the rgb to hsl converter core
// no dependencies; used by rgb_to_hsl_converter_core

package rgb2hsl_pkg;

  localparam int ChanW = 8;   // color channel code
  localparam int SumW  = 9;   // max + min
  localparam int HueW  = 15;  // hue, 1/64 degree
  localparam int FracW = 16;  // fraction: q1.15 for lightness, unsigned q1.15 for saturation
  localparam int QuotW = 16;  // quotient bits resolved by the divider pipe
  localparam int RemW  = 25;  // dividend / partial remainder width
  localparam int DivW  = 9;   // doubled divisor width (2*d, 2*den)
  localparam int RecipW = 24; // reciprocal of 255, 31 fraction bits
  localparam int LitW  = 47;  // scaled lightness product, result in the top 16 bits

  // 60 degrees in 1/64 degree units
  localparam logic [HueW-1:0] HueSextant = 15'd3840;
  // 2 * 3840, scale of the doubled hue dividend
  localparam logic [RemW-1:0] HueScale2  = 25'd7680;
  // lightness = floor((16384 * sum + 127) / 255), 255 replaced by ceil(2^31 / 255)
  localparam logic [RecipW-1:0] LitRecip = 24'd8421505;
  // 127 * LitRecip, the round half up term
  localparam logic [LitW-1:0]   LitBias  = 47'd1069531135;
  localparam logic [SumW-1:0] SumFull    = 9'd510;
  localparam logic [SumW-1:0] SumHalf    = 9'd255;

  typedef enum logic [1:0] {
    MaxRed,
    MaxGreen,
    MaxBlue
  } max_sel_e;

  // hue base for a sextant index 0..5
  function automatic logic [HueW-1:0] sextant_base(input logic [2:0] idx);
    logic [HueW-1:0] base;
    case (idx)
      3'd0:    base = 15'd0;
      3'd1:    base = 15'd3840;
      3'd2:    base = 15'd7680;
      3'd3:    base = 15'd11520;
      3'd4:    base = 15'd15360;
      3'd5:    base = 15'd19200;
      default: base = 15'd0;
    endcase
    return base;
  endfunction

endpackage

// ===== rtl/core/rgb_to_hsl_converter_core.sv =====
// rgb_to_hsl_converter_core: pipelined rgba pixel to hue / saturation / lightness
// depends on rgb2hsl_pkg

// channel   direction  handshake          words
// -------   ---------  ---------          -----
// pixel     in         start_i, busy_o    red_in_i, green_in_i, blue_in_i, alpha_in_i
// hsl       out        done_o (strobe)    hue_o, saturation_o, lightness_o, alpha_out_o
//
// one pixel word may enter every cycle; busy_o stays low
// a result leaves on done_o in input order
// the path runs through three front stages (a, b, c), the 16 restoring divider
// stages (one quotient bit each) and the output register
// rst_ni clears the valid bits only; the receiver cannot stall, so nothing waits

module rgb_to_hsl_converter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [rgb2hsl_pkg::ChanW-1:0]       red_in_i,
  input  logic [rgb2hsl_pkg::ChanW-1:0]       green_in_i,
  input  logic [rgb2hsl_pkg::ChanW-1:0]       blue_in_i,
  input  logic [rgb2hsl_pkg::ChanW-1:0]       alpha_in_i,
  output logic                                done_o,
  output logic [rgb2hsl_pkg::HueW-1:0]        hue_o,
  output logic [rgb2hsl_pkg::FracW-1:0]       saturation_o,
  output logic [rgb2hsl_pkg::FracW-1:0]       lightness_o,
  output logic [rgb2hsl_pkg::ChanW-1:0]       alpha_out_o
);

  localparam int CW = rgb2hsl_pkg::ChanW;
  localparam int SW = rgb2hsl_pkg::SumW;
  localparam int HW = rgb2hsl_pkg::HueW;
  localparam int FW = rgb2hsl_pkg::FracW;
  localparam int QW = rgb2hsl_pkg::QuotW;
  localparam int RW = rgb2hsl_pkg::RemW;
  localparam int DW = rgb2hsl_pkg::DivW;
  localparam int LW = rgb2hsl_pkg::LitW;
  localparam int PW = SW + rgb2hsl_pkg::RecipW;

  // fully pipelined, never refuses a word
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i & ~busy_o;

  // ---------------------------------------------------------------------------
  // stage a: pick max channel (tie rule: later candidate wins) and min
  // ---------------------------------------------------------------------------
  rgb2hsl_pkg::max_sel_e a_sel_d, a_sel_q;
  logic [CW-1:0] a_mx_d, a_mn_d;
  logic [CW-1:0] a_r_q, a_g_q, a_b_q, a_alpha_q, a_mx_q, a_mn_q;
  logic          a_valid_q;

  always_comb begin
    if (red_in_i > green_in_i) begin
      a_sel_d = (red_in_i > blue_in_i) ? rgb2hsl_pkg::MaxRed : rgb2hsl_pkg::MaxBlue;
      a_mn_d  = (green_in_i < blue_in_i) ? green_in_i : blue_in_i;
    end else begin
      a_sel_d = (green_in_i > blue_in_i) ? rgb2hsl_pkg::MaxGreen : rgb2hsl_pkg::MaxBlue;
      a_mn_d  = (red_in_i < blue_in_i) ? red_in_i : blue_in_i;
    end
    case (a_sel_d)
      rgb2hsl_pkg::MaxRed:   a_mx_d = red_in_i;
      rgb2hsl_pkg::MaxGreen: a_mx_d = green_in_i;
      default:               a_mx_d = blue_in_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    a_r_q     <= red_in_i;
    a_g_q     <= green_in_i;
    a_b_q     <= blue_in_i;
    a_alpha_q <= alpha_in_i;
    a_mx_q    <= a_mx_d;
    a_mn_q    <= a_mn_d;
    a_sel_q   <= a_sel_d;
  end

  // ---------------------------------------------------------------------------
  // stage b: spread, sum, saturation denominator, hue sextant and fraction
  // hue = base(sextant) + round(3840 * f / d) with 0 <= f <= d
  // ---------------------------------------------------------------------------
  logic [CW-1:0] b_d_d, b_f_d, b_den_d;
  logic [SW-1:0] b_sum_d;
  logic [2:0]    b_sext_d;
  logic [CW-1:0] b_d_q, b_f_q, b_den_q, b_alpha_q;
  logic [SW-1:0] b_sum_q;
  logic [HW-1:0] b_base_q;
  logic          b_grey_q, b_valid_q;

  always_comb begin
    b_d_d   = a_mx_q - a_mn_q;
    b_sum_d = {1'b0, a_mx_q} + {1'b0, a_mn_q};
    // fold around one half: 510 - sum stays below 256 when sum > 255
    if (b_sum_d <= rgb2hsl_pkg::SumHalf) begin
      b_den_d = b_sum_d[CW-1:0];
    end else begin
      b_den_d = CW'(rgb2hsl_pkg::SumFull - b_sum_d);
    end
    b_f_d    = '0;
    b_sext_d = 3'd0;
    case (a_sel_q)
      rgb2hsl_pkg::MaxRed: begin
        if (a_g_q >= a_b_q) begin
          b_f_d    = a_g_q - a_b_q;
          b_sext_d = 3'd0;
        end else begin
          // wrap: negative angle lands in the last sextant
          b_f_d    = b_d_d - (a_b_q - a_g_q);
          b_sext_d = 3'd5;
        end
      end
      rgb2hsl_pkg::MaxGreen: begin
        if (a_b_q >= a_r_q) begin
          b_f_d    = a_b_q - a_r_q;
          b_sext_d = 3'd2;
        end else begin
          b_f_d    = b_d_d - (a_r_q - a_b_q);
          b_sext_d = 3'd1;
        end
      end
      default: begin
        if (a_r_q >= a_g_q) begin
          b_f_d    = a_r_q - a_g_q;
          b_sext_d = 3'd4;
        end else begin
          b_f_d    = b_d_d - (a_g_q - a_r_q);
          b_sext_d = 3'd3;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_d_q     <= b_d_d;
    b_f_q     <= b_f_d;
    b_sum_q   <= b_sum_d;
    b_den_q   <= b_den_d;
    b_base_q  <= rgb2hsl_pkg::sextant_base(b_sext_d);
    b_grey_q  <= (b_d_d == '0);
    b_alpha_q <= a_alpha_q;
  end

  // ---------------------------------------------------------------------------
  // stage c: doubled dividends and divisors, round half up as (2n + den) / 2den
  // lightness is done here by reciprocal multiply, exact for every sum 0..510
  // index 0 of the divider arrays is this stage's register
  // ---------------------------------------------------------------------------
  logic [PW-1:0] c_lit_p;
  logic [LW-1:0] c_lit_t;

  logic          dv_valid_q [0:QW];
  logic [RW-1:0] hrem_q     [0:QW];
  logic [RW-1:0] srem_q     [0:QW];
  logic [DW-1:0] hdiv_q     [0:QW];
  logic [DW-1:0] sdiv_q     [0:QW];
  logic [QW-1:0] hq_q       [0:QW];
  logic [QW-1:0] sq_q       [0:QW];
  logic [FW-1:0] lit_stage_q [0:QW];
  logic [HW-1:0] base_q     [0:QW];
  logic          grey_q     [0:QW];
  logic [CW-1:0] alpha_q    [0:QW];

  // (16384 * sum + 127) * recip, sum scaled up by 2^14 after the small multiply
  always_comb begin
    c_lit_p = PW'(b_sum_q) * PW'(rgb2hsl_pkg::LitRecip);
    c_lit_t = {c_lit_p, {(LW-PW){1'b0}}} + rgb2hsl_pkg::LitBias;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid_q[0] <= 1'b0;
    end else begin
      dv_valid_q[0] <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hrem_q[0]      <= RW'(b_f_q) * rgb2hsl_pkg::HueScale2 + RW'(b_d_q);
    srem_q[0]      <= {1'b0, b_d_q, 16'b0} + RW'(b_den_q);
    hdiv_q[0]      <= {b_d_q, 1'b0};
    sdiv_q[0]      <= {b_den_q, 1'b0};
    hq_q[0]        <= '0;
    sq_q[0]        <= '0;
    lit_stage_q[0] <= c_lit_t[LW-1:LW-FW];
    base_q[0]      <= b_base_q;
    grey_q[0]      <= b_grey_q;
    alpha_q[0]     <= b_alpha_q;
  end

  // ---------------------------------------------------------------------------
  // restoring divider pipe: stage k settles quotient bit QW-1-k for hue and
  // saturation; a zero divisor (grey pixel) runs through harmlessly and is
  // masked at the end
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int Sh = QW - 1 - k;

    logic [RW:0]   h_trial, s_trial;
    logic          h_bit, s_bit;
    logic [RW-1:0] h_rem_d, s_rem_d;

    always_comb begin
      h_trial = {1'b0, hrem_q[k]} - ({1'b0, RW'(hdiv_q[k])} << Sh);
      s_trial = {1'b0, srem_q[k]} - ({1'b0, RW'(sdiv_q[k])} << Sh);
      h_bit   = ~h_trial[RW];
      s_bit   = ~s_trial[RW];
      h_rem_d = h_bit ? h_trial[RW-1:0] : hrem_q[k];
      s_rem_d = s_bit ? s_trial[RW-1:0] : srem_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[k+1] <= 1'b0;
      end else begin
        dv_valid_q[k+1] <= dv_valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      hrem_q[k+1]      <= h_rem_d;
      srem_q[k+1]      <= s_rem_d;
      hdiv_q[k+1]      <= hdiv_q[k];
      sdiv_q[k+1]      <= sdiv_q[k];
      hq_q[k+1]        <= {hq_q[k][QW-2:0], h_bit};
      sq_q[k+1]        <= {sq_q[k][QW-2:0], s_bit};
      lit_stage_q[k+1] <= lit_stage_q[k];
      base_q[k+1]      <= base_q[k];
      grey_q[k+1]      <= grey_q[k];
      alpha_q[k+1]     <= alpha_q[k];
    end
  end

  // ---------------------------------------------------------------------------
  // output register: add sextant base, force hue and saturation to zero on grey
  // ---------------------------------------------------------------------------
  logic          done_q;
  logic [HW-1:0] hue_q;
  logic [FW-1:0] sat_q, lit_q;
  logic [CW-1:0] alpha_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q       <= grey_q[QW] ? '0 : base_q[QW] + HW'(hq_q[QW]);
    sat_q       <= grey_q[QW] ? '0 : sq_q[QW];
    lit_q       <= lit_stage_q[QW];
    alpha_out_q <= alpha_q[QW];
  end

  assign done_o       = done_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign lightness_o  = lit_q;
  assign alpha_out_o  = alpha_out_q;

endmodule
